@@ rtl/core/lzss_pkg.sv @@
// shared types and constants for the lzss window match encoder
`timescale 1ns / 1ps
package lzss_pkg;
  localparam int MaxWindowBits  = 10;
  localparam int HistSize       = 1 << MaxWindowBits;
  localparam int LookaheadDepth = 32;
  localparam int LaIdxW         = $clog2(LookaheadDepth);
  localparam int LaCntW         = $clog2(LookaheadDepth + 1);
  localparam int HistCntW       = $clog2(HistSize + 1);

  localparam logic [1:0] CfgWindowBits = 2'd0;
  localparam logic [1:0] CfgLengthBits = 2'd1;
  localparam logic [1:0] CfgMinMatch   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_match;
    logic [9:0] offset_code;
    logic [3:0] length_code;
    logic [7:0] literal;
    logic       last_token;
  } out_item_t;
endpackage

@@ rtl/core/lzss_cell.sv @@
// one compare cell: holds one history byte of the scan window and checks it against one lookahead byte
`timescale 1ns / 1ps
module lzss_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] hist_in,
  output logic [7:0] hist_out,
  input  logic [7:0] la_byte,
  input  logic       in_range,
  input  logic       alive_in,
  output logic       alive_out
);
  // history bytes move one cell further from the read port per scanned distance
  always_ff @(posedge clk) begin
    if (shift) begin
      hist_out <= hist_in;
    end
  end

  // a cell extends the run of its left neighbor when its byte also matches
  assign alive_out = alive_in && in_range && (hist_out == la_byte);
endmodule

@@ rtl/core/lzss_window_match_encoder.sv @@
// top level: lzss token encoder over a history window
//
// Bytes enter the lookahead buffer one per transfer. A byte that completes no
// token passes through the transfer and a check. A token decision starts with a
// check, then scans the window one distance per cycle, nearest first, over
// span distances where span is min(2^window_bits, valid history bytes), at most
// 1024 (no scan when the history is empty); each cycle reads one history
// byte from the ring memory into a chain of compare cells, which find the run
// length at that distance against the lookahead in parallel. A decide state sets
// up the token, which then waits for out_ready, and the matched or literal bytes
// move into history at one byte per cycle. A final byte flushes all buffered
// bytes as consecutive tokens, then the window restarts empty.
`timescale 1ns / 1ps
module lzss_window_match_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lzss_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lzss_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_data
);
  localparam int LD = lzss_pkg::LookaheadDepth;
  localparam int CW = lzss_pkg::LaCntW;
  localparam int HW = lzss_pkg::MaxWindowBits;
  localparam int FW = lzss_pkg::HistCntW;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_OUT, S_PUSH
  } state_t;

  state_t state;
  logic [3:0] window_bits;
  logic [2:0] length_bits;
  logic [4:0] min_match;

  logic [7:0]    hist_mem [lzss_pkg::HistSize];
  logic [7:0]    la [LD];
  logic [CW-1:0] la_fill;
  logic [FW-1:0] hist_fill;
  logic [HW-1:0] write_head;
  logic          last_flag;

  logic [HW:0]   span;
  logic [CW-1:0] limit;
  logic [CW-1:0] best_len;
  logic [HW:0]   best_dist;
  logic [7:0]    rd_byte;
  logic [HW:0]   rd_d;        // next distance to read
  logic          v1;          // rd_byte holds distance d1
  logic [HW:0]   d1;
  logic          v2;          // cell chain holds the window for distance d2
  logic [HW:0]   d2;
  logic [CW-1:0] push_cnt;
  logic [CW-1:0] push_n;

  // effective config
  logic [4:0]    mm_eff;
  logic [8:0]    max_len_raw;
  logic [CW-1:0] max_len;
  logic [3:0]    wb_eff;
  logic [HW:0]   win_size;
  logic [HW:0]   scan_span;
  logic [CW-1:0] scan_limit;
  always_comb begin
    mm_eff      = (min_match == 5'd0) ? 5'd1 : min_match;
    max_len_raw = (9'd1 << length_bits) + 9'(mm_eff) - 9'd1;
    max_len     = (max_len_raw > 9'(LD)) ? CW'(LD) : CW'(max_len_raw);
    wb_eff      = (window_bits > 4'(HW)) ? 4'(HW) : window_bits;
    win_size    = (HW+1)'(1) << wb_eff;
    scan_span   = (win_size > (HW+1)'(hist_fill)) ? (HW+1)'(hist_fill) : win_size;
    scan_limit  = (max_len > la_fill) ? la_fill : max_len;
  end

  // cell j holds the history byte at distance d2 - j
  logic [7:0]    win [LD];
  logic [LD:0]   alive;
  logic [LD-1:0] rng;
  logic          cell_shift;
  logic [CW-1:0] run_len;

  assign cell_shift = (state == S_SCAN) && v1;
  assign alive[0]   = 1'b1;

  always_comb begin
    for (int j = 0; j < LD; j++) begin
      rng[j] = (CW'(j) < limit) && ((HW+1)'(j) < d2);
    end
  end

  for (genvar c = 0; c < LD; c++) begin : g_cell
    logic [7:0] src;
    if (c == 0) begin : g_head
      assign src = rd_byte;
    end else begin : g_body
      assign src = win[c-1];
    end
    lzss_cell u_cell (
      .clk       (clk),
      .shift     (cell_shift),
      .hist_in   (src),
      .hist_out  (win[c]),
      .la_byte   (la[c]),
      .in_range  (rng[c]),
      .alive_in  (alive[c]),
      .alive_out (alive[c+1])
    );
  end

  always_comb begin
    run_len = '0;
    for (int j = 1; j <= LD; j++) begin
      if (alive[j]) run_len = CW'(j);
    end
  end

  assign in_ready = (state == S_IDLE);

  logic emit_any;
  logic take_match;
  assign emit_any   = (la_fill != '0) && ((la_fill >= max_len) || last_flag);
  assign take_match = (best_len >= CW'(mm_eff));

  always_ff @(posedge clk) begin
    if (state == S_SCAN && rd_d <= span) begin
      rd_byte <= hist_mem[write_head - rd_d[HW-1:0]];
    end
    if (state == S_PUSH) begin
      hist_mem[write_head] <= la[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_bits <= 4'd10;
      length_bits <= 3'd4;
      min_match   <= 5'd3;
      la_fill     <= '0;
      hist_fill   <= '0;
      write_head  <= '0;
      out_valid   <= 1'b0;
      last_flag   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lzss_pkg::CfgWindowBits: window_bits <= cfg_data[3:0];
          lzss_pkg::CfgLengthBits: length_bits <= cfg_data[2:0];
          lzss_pkg::CfgMinMatch:   min_match   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (la_fill < CW'(LD)) begin
              la[la_fill[lzss_pkg::LaIdxW-1:0]] <= in_data.data_byte;
              la_fill <= la_fill + CW'(1);
            end
            last_flag <= in_data.last_byte;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (emit_any) begin
            span      <= scan_span;
            limit     <= scan_limit;
            best_len  <= '0;
            best_dist <= '0;
            rd_d      <= (HW+1)'(1);
            v1        <= 1'b0;
            v2        <= 1'b0;
            // empty history gives a literal with no scan
            if (scan_span == '0) state <= S_DECIDE;
            else state <= S_SCAN;
          end else begin
            if (last_flag) begin
              hist_fill  <= '0;
              write_head <= '0;
              la_fill    <= '0;
              last_flag  <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (rd_d <= span) begin
            v1   <= 1'b1;
            d1   <= rd_d;
            rd_d <= rd_d + (HW+1)'(1);
          end else begin
            v1 <= 1'b0;
          end
          v2 <= v1;
          d2 <= d1;
          // strictly longer only, so the nearest distance wins ties
          if (v2) begin
            if (run_len > best_len) begin
              best_len  <= run_len;
              best_dist <= d2;
            end
            if (d2 == span) state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          out_valid <= 1'b1;
          if (take_match) begin
            out_data.is_match    <= 1'b1;
            out_data.offset_code <= 10'(best_dist - (HW+1)'(1));
            out_data.length_code <= 4'(best_len - CW'(mm_eff));
            out_data.literal     <= 8'd0;
            push_n <= best_len;
          end else begin
            out_data.is_match    <= 1'b0;
            out_data.offset_code <= '0;
            out_data.length_code <= '0;
            out_data.literal     <= la[0];
            push_n <= CW'(1);
          end
          out_data.last_token <= last_flag &&
            (la_fill == (take_match ? best_len : CW'(1)));
          push_cnt <= '0;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_PUSH;
          end
        end
        S_PUSH: begin
          for (int k = 0; k < LD - 1; k++) la[k] <= la[k+1];
          la_fill    <= la_fill - CW'(1);
          write_head <= write_head + HW'(1);
          if (hist_fill < FW'(lzss_pkg::HistSize)) hist_fill <= hist_fill + FW'(1);
          push_cnt <= push_cnt + CW'(1);
          if (push_cnt + CW'(1) == push_n) state <= S_CHECK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
